// ----- rtl/edf_pkg.sv -----
// Package for the earliest-deadline-first ranker.
// Holds shared constants, command codes and the controller/datapath link types.
// No dependencies.
`default_nettype none

package edf_pkg;

  // Default number of task slots held in the stores.
  localparam int unsigned MAX_TASKS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned ACTIVE_W = 4;

  // The active task count comes up at six after reset.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd6;

  // Input command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // write one slot's period and deadline
    logic sched;  // advance expired deadlines at the current time
    logic rank;   // rank the slot selected by the step index
    logic emit;   // present the result at the step index
  } edf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;     // step index is the last active slot
    logic none_active;  // no slot takes part in scheduling
  } edf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/edf_ctrl.sv -----
// Controller for the earliest-deadline-first ranker.
// Sequences the rank and emit passes and steps the slot index.
// Depends on edf_pkg.
`default_nettype none

module edf_ctrl #(
  parameter int unsigned MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_TASKS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_command,
  input  wire edf_pkg::edf_stat_t stat,
  output logic                   busy,
  output edf_pkg::edf_cmd_t      cmd,
  output logic [IDX_W-1:0]       idx
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             take;

  assign busy = (state_r != ST_IDLE);
  assign take = start && !busy;
  assign idx  = idx_r;

  // Next state, step index and datapath commands.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_command == edf_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.sched = 1'b1;
            idx_nxt   = '0;
            if (!stat.none_active) begin
              state_nxt = ST_RANK;
            end
          end
        end
      end
      ST_RANK: begin
        cmd.rank = 1'b1;
        if (stat.idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // State and index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/edf_dpath.sv -----
// Datapath for the earliest-deadline-first ranker.
// Holds the task stores, the active count, the rank tables and the result register.
// Depends on edf_pkg.
`default_nettype none

module edf_dpath #(
  parameter int unsigned MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_TASKS),
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire edf_pkg::edf_cmd_t             cmd,
  input  wire logic [IDX_W-1:0]              idx,
  output edf_pkg::edf_stat_t                 stat,
  input  wire logic                          cfg_we,
  input  wire logic [edf_pkg::ACTIVE_W-1:0]  cfg_wdata,
  input  wire logic [edf_pkg::SLOT_W-1:0]    in_task_slot,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_task_period,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_first_deadline,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_current_time,
  output logic                               out_valid,
  output logic [edf_pkg::SLOT_W-1:0]         out_ranked_task,
  output logic [edf_pkg::SLOT_W-1:0]         out_rank,
  output logic [edf_pkg::TIME_W-1:0]         out_task_deadline,
  output logic                               out_last
);

  logic [edf_pkg::ACTIVE_W-1:0] active_r;
  logic [CNT_W-1:0]             n_cnt;

  logic [edf_pkg::TIME_W-1:0] dl_r  [MAX_TASKS];
  logic [edf_pkg::TIME_W-1:0] per_r [MAX_TASKS];

  logic [IDX_W-1:0]           rank_slot_r [MAX_TASKS];
  logic [edf_pkg::TIME_W-1:0] rank_dl_r   [MAX_TASKS];

  logic [MAX_TASKS-1:0]       act;
  logic [MAX_TASKS-1:0]       upd;
  logic [MAX_TASKS-1:0]       earlier;
  logic [edf_pkg::TIME_W-1:0] dl_sel;
  logic [IDX_W-1:0]           pos;

  logic                       out_valid_r;
  logic                       out_last_r;
  logic [edf_pkg::SLOT_W-1:0] out_slot_r;
  logic [edf_pkg::SLOT_W-1:0] out_rank_r;
  logic [edf_pkg::TIME_W-1:0] out_dl_r;

  // Active task count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= edf_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // The count saturates at the number of slots held.
  always_comb begin
    if (32'(active_r) > 32'(MAX_TASKS)) begin
      n_cnt = CNT_W'(MAX_TASKS);
    end else begin
      n_cnt = CNT_W'(active_r);
    end
  end

  // Status for the controller.
  assign stat.idx_last    = ((CNT_W'(idx) + CNT_W'(1)) == n_cnt);
  assign stat.none_active = (n_cnt == '0);

  // Per-slot active flags and expired-deadline flags.
  always_comb begin
    for (int k = 0; k < MAX_TASKS; k++) begin
      act[k] = (32'(k) < 32'(n_cnt));
      upd[k] = act[k] && (in_current_time >= dl_r[k]);
    end
  end

  // Task stores: a load writes one slot, a schedule advances every expired active slot once.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (cmd.load && (32'(in_task_slot) == 32'(k))) begin
        per_r[k] <= in_task_period;
        dl_r[k]  <= in_first_deadline;
      end else if (cmd.sched && upd[k]) begin
        dl_r[k] <= dl_r[k] + per_r[k];
      end
    end
  end

  // Rank of the selected slot: count of active slots that come before it.
  // Ties go to the lower slot index.
  always_comb begin
    dl_sel = dl_r[idx];
    for (int j = 0; j < MAX_TASKS; j++) begin
      earlier[j] = act[j] && (32'(j) != 32'(idx)) &&
                   ((dl_r[j] < dl_sel) ||
                    ((dl_r[j] == dl_sel) && (32'(j) < 32'(idx))));
    end
    pos = IDX_W'($countones(earlier));
  end

  // Rank tables, filled one slot per cycle in slot order, each slot at its rank position.
  always_ff @(posedge clk) begin
    if (cmd.rank) begin
      rank_slot_r[pos] <= idx;
      rank_dl_r[pos]   <= dl_sel;
    end
  end

  // Result register: one transfer per emit step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r <= edf_pkg::SLOT_W'(rank_slot_r[idx]);
      out_rank_r <= edf_pkg::SLOT_W'(idx);
      out_dl_r   <= rank_dl_r[idx];
      out_last_r <= stat.idx_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ranked_task   = out_slot_r;
  assign out_rank          = out_rank_r;
  assign out_task_deadline = out_dl_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/edf_deadline_ranker.sv -----
// Earliest-deadline-first ranker, top level. Depends on edf_pkg, edf_ctrl, edf_dpath.
// A load writes its slot and gives no result; busy stays low. A schedule with n active
// tasks runs one rank step per task and then one emit step per task; each emit step
// is registered into the result outputs, and busy is high through both passes.
// The receiver cannot stall; one result per cycle. Synchronous active-low reset
// sets the active count to six; the task stores hold nothing until loaded.
`default_nettype none

module edf_deadline_ranker #(
  parameter int unsigned MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [edf_pkg::SLOT_W-1:0]    in_task_slot,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_task_period,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_first_deadline,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_current_time,
  output logic                               out_valid,
  output logic [edf_pkg::SLOT_W-1:0]         out_ranked_task,
  output logic [edf_pkg::SLOT_W-1:0]         out_rank,
  output logic [edf_pkg::TIME_W-1:0]         out_task_deadline,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [edf_pkg::ACTIVE_W-1:0]  cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);

  edf_pkg::edf_cmd_t  cmd;
  edf_pkg::edf_stat_t stat;
  logic [IDX_W-1:0]   idx;

  // Sequencer.
  edf_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd),
    .idx        (idx)
  );

  // Stores, ranking and result register.
  edf_dpath #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .idx               (idx),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_task_slot      (in_task_slot),
    .in_task_period    (in_task_period),
    .in_first_deadline (in_first_deadline),
    .in_current_time   (in_current_time),
    .out_valid         (out_valid),
    .out_ranked_task   (out_ranked_task),
    .out_rank          (out_rank),
    .out_task_deadline (out_task_deadline),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the earliest-deadline-first ranker.
// Loads task slots, schedules at chosen times and checks each ranked result.
// Depends on edf_pkg and edf_deadline_ranker.
`default_nettype none

module tb_top;

  localparam int unsigned SLOTS         = edf_pkg::MAX_TASKS_DEF;
  localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // One command as the driver presents it.
  typedef struct packed {
    logic                       cmd;
    logic [edf_pkg::SLOT_W-1:0] slot;
    logic [edf_pkg::TIME_W-1:0] period;
    logic [edf_pkg::TIME_W-1:0] first_dl;
    logic [edf_pkg::TIME_W-1:0] now;
  } edf_item_t;

  // One ranked entry as the block reports it.
  typedef struct packed {
    logic [edf_pkg::SLOT_W-1:0] slot;
    logic [edf_pkg::SLOT_W-1:0] rank;
    logic [edf_pkg::TIME_W-1:0] deadline;
    logic                       last;
  } rank_entry_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_command = edf_pkg::CMD_LOAD;
  logic [edf_pkg::SLOT_W-1:0]   in_task_slot = '0;
  logic [edf_pkg::TIME_W-1:0]   in_task_period = '0;
  logic [edf_pkg::TIME_W-1:0]   in_first_deadline = '0;
  logic [edf_pkg::TIME_W-1:0]   in_current_time = '0;
  logic                         out_valid;
  logic [edf_pkg::SLOT_W-1:0]   out_ranked_task;
  logic [edf_pkg::SLOT_W-1:0]   out_rank;
  logic [edf_pkg::TIME_W-1:0]   out_task_deadline;
  logic                         out_last;
  logic                         cfg_we = 1'b0;
  logic [edf_pkg::ACTIVE_W-1:0] cfg_wdata = '0;

  // Shadow of the block's task stores and active count.
  logic [edf_pkg::TIME_W-1:0]   deadline_mem [SLOTS];
  logic [edf_pkg::TIME_W-1:0]   period_mem [SLOTS];
  logic [edf_pkg::ACTIVE_W-1:0] active_n = edf_pkg::ACTIVE_RESET;

  edf_item_t                    pending_cmds [$];
  rank_entry_t                  due_ranks [$];
  edf_item_t                    cur_cmd;
  int unsigned                  idle_pct = 0;
  int unsigned                  mismatch_count = 0;
  int unsigned                  cycle_count = 0;
  logic [edf_pkg::TIME_W-1:0]   tick_base;

  edf_deadline_ranker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_task_slot      (in_task_slot),
    .in_task_period    (in_task_period),
    .in_first_deadline (in_first_deadline),
    .in_current_time   (in_current_time),
    .out_valid         (out_valid),
    .out_ranked_task   (out_ranked_task),
    .out_rank          (out_rank),
    .out_task_deadline (out_task_deadline),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted command to the shadow stores and queue the ranking it causes.
  task automatic advance_and_rank(input edf_item_t it);
    int unsigned n;
    int unsigned pos;
    int unsigned order [SLOTS];
    rank_entry_t ent;
    if (it.cmd == edf_pkg::CMD_LOAD) begin
      period_mem[it.slot]   = it.period;
      deadline_mem[it.slot] = it.first_dl;
    end else begin
      n = (32'(active_n) > SLOTS) ? SLOTS : 32'(active_n);
      // Every expired active deadline moves on by one period, wrapping at 2^32.
      for (int unsigned i = 0; i < n; i++) begin
        if (it.now >= deadline_mem[i]) deadline_mem[i] = deadline_mem[i] + period_mem[i];
      end
      // Position of each slot is the count of slots ahead of it; ties go to the lower index.
      for (int unsigned i = 0; i < n; i++) begin
        pos = 0;
        for (int unsigned j = 0; j < n; j++) begin
          if (j != i && (deadline_mem[j] < deadline_mem[i] ||
                         (deadline_mem[j] == deadline_mem[i] && j < i))) pos++;
        end
        order[pos] = i;
      end
      for (int unsigned r = 0; r < n; r++) begin
        ent.slot     = edf_pkg::SLOT_W'(order[r]);
        ent.rank     = edf_pkg::SLOT_W'(r);
        ent.deadline = deadline_mem[order[r]];
        ent.last     = (r + 1 == n);
        due_ranks.push_back(ent);
      end
    end
  endtask

  // Driver: a command transfers when start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) advance_and_rank(cur_cmd);
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          in_command        <= cur_cmd.cmd;
          in_task_slot      <= cur_cmd.slot;
          in_task_period    <= cur_cmd.period;
          in_first_deadline <= cur_cmd.first_dl;
          in_current_time   <= cur_cmd.now;
          start             <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest predicted entry.
  always @(posedge clk) begin
    rank_entry_t got;
    rank_entry_t want;
    if (rst_n && out_valid) begin
      got = '{out_ranked_task, out_rank, out_task_deadline, out_last};
      if (due_ranks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result task %0d rank %0d deadline %h last %0d",
                 $time, got.slot, got.rank, got.deadline, got.last);
      end else begin
        want = due_ranks.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected task %0d rank %0d deadline %h last %0d", $time,
                   want.slot, want.rank, want.deadline, want.last);
          $display("%0t:   actual task %0d rank %0d deadline %h last %0d", $time,
                   got.slot, got.rank, got.deadline, got.last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** edf_deadline_ranker: FAILED **");
      $finish;
    end
  end

  task automatic push_cmd(input logic cmd, input int unsigned slot,
                          input logic [edf_pkg::TIME_W-1:0] period,
                          input logic [edf_pkg::TIME_W-1:0] dl,
                          input logic [edf_pkg::TIME_W-1:0] now);
    edf_item_t it;
    it.cmd      = cmd;
    it.slot     = edf_pkg::SLOT_W'(slot);
    it.period   = period;
    it.first_dl = dl;
    it.now      = now;
    pending_cmds.push_back(it);
  endtask

  // Wait until every command has transferred and the block has gone quiet.
  task automatic drain_and_settle();
    while (pending_cmds.size() != 0 || start || busy || due_ranks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One phase: set the active count while idle, then send random loads and schedules.
  task automatic run_phase(input logic [edf_pkg::ACTIVE_W-1:0] active,
                           input int unsigned idle, input int unsigned count,
                           input logic [edf_pkg::TIME_W-1:0] base);
    logic [edf_pkg::TIME_W-1:0] period;
    logic [edf_pkg::TIME_W-1:0] dl;
    logic [edf_pkg::TIME_W-1:0] now;
    int unsigned                pick;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= active;
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_n  = active;
    idle_pct  = idle;
    tick_base = base;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 55) begin
        // Mostly short periods near the running time, so deadlines collide and expire.
        if (pick < 70) period = $urandom_range(1, 40);
        else if (pick < 80) period = '0;
        else period = $urandom;
        dl = ($urandom_range(99) < 80) ? tick_base + $urandom_range(0, 30) : $urandom;
        push_cmd(edf_pkg::CMD_LOAD, $urandom_range(SLOTS - 1), period, dl, $urandom);
      end else begin
        now = ($urandom_range(99) < 75) ? tick_base + $urandom_range(0, 40) : $urandom;
        push_cmd(edf_pkg::CMD_SCHED, $urandom, $urandom, $urandom, now);
        tick_base = tick_base + $urandom_range(0, 12);
      end
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset count of six: every slot is loaded before any schedule.
    push_cmd(edf_pkg::CMD_LOAD, 0, 32'd10, 32'd100, '0);
    push_cmd(edf_pkg::CMD_LOAD, 1, 32'd0, 32'd100, '0);
    push_cmd(edf_pkg::CMD_LOAD, 2, 32'hFFFF_FFFF, 32'd0, '0);
    push_cmd(edf_pkg::CMD_LOAD, 3, 32'd5, 32'hFFFF_FFFF, '0);
    push_cmd(edf_pkg::CMD_LOAD, 4, 32'd1, 32'd50, '0);
    push_cmd(edf_pkg::CMD_LOAD, 5, 32'd20, 32'd100, '0);
    push_cmd(edf_pkg::CMD_LOAD, 6, 32'd7, 32'd3, '0);
    push_cmd(edf_pkg::CMD_LOAD, 7, 32'd1234, 32'd0, '0);
    // Time zero expires only the zero deadline; it then ties with the all-ones one.
    push_cmd(edf_pkg::CMD_SCHED, 0, '0, '0, 32'd0);
    push_cmd(edf_pkg::CMD_SCHED, 7, '1, '1, 32'd99);
    // Deadline equal to the time counts as expired; a zero period leaves it in place.
    push_cmd(edf_pkg::CMD_SCHED, 3, '0, '0, 32'd100);
    // All-ones time expires everything and wraps the large deadlines.
    push_cmd(edf_pkg::CMD_SCHED, 5, '0, '1, 32'hFFFF_FFFF);
    // Loads to inactive slots still land in the stores.
    push_cmd(edf_pkg::CMD_LOAD, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    push_cmd(edf_pkg::CMD_LOAD, 7, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    push_cmd(edf_pkg::CMD_SCHED, 2, '0, '0, 32'hFFFF_FFFE);
    push_cmd(edf_pkg::CMD_SCHED, 1, '0, '0, 32'h8000_0000);
    drain_and_settle();

    // Count sweep with the extremes: all slots, one, none, saturating values.
    run_phase(4'd8, 0, 30, 32'd1000);
    run_phase(4'd1, 62, 15, 32'd5000);
    run_phase(4'd0, 22, 10, 32'd200);
    run_phase(4'd15, 62, 25, 32'hFFFF_FF80);
    run_phase(4'd3, 22, 20, 32'd40);
    run_phase(4'd8, 22, 30, 32'h7FFF_FFE0);
    run_phase(4'd5, 0, 20, 32'd9000);
    run_phase(4'd9, 62, 20, 32'hFFFF_FFF0);

    if (mismatch_count == 0) begin
      $display("** edf_deadline_ranker: PASSED **");
    end else begin
      $display("** edf_deadline_ranker: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
